// ----- design/overlay_fragment_blend_defines.svh -----
// Assertion helpers for the overlay blender.
// Both sample on clk and are held off while rst_n is low.
`ifndef OVERLAY_FRAGMENT_BLEND_DEFINES_SVH
`define OVERLAY_FRAGMENT_BLEND_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OFB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ofb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ofb_pkg;

    localparam int CH_W        = 8;
    localparam int CHANNELS    = 4;
    localparam int PIX_W       = CH_W * CHANNELS;
    localparam int POS_W       = 9;
    localparam int FRAME_W     = 10;
    localparam int CLIP_W      = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int ADDR_PROD_W = POS_W + FRAME_W;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    localparam int ROUND_BIAS = 127;
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH  = 10'd512;
    localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT = 10'd512;
    localparam logic [CLIP_W-1:0]  RST_CLIP_LEFT    = 9'd0;
    localparam logic [CLIP_W-1:0]  RST_CLIP_TOP     = 9'd0;
    localparam logic [CLIP_W-1:0]  RST_CLIP_RIGHT   = 9'd511;
    localparam logic [CLIP_W-1:0]  RST_CLIP_BOTTOM  = 9'd511;

    typedef enum logic [1:0] {
        OP_BLEND,
        OP_TINT,
        OP_READ,
        OP_FRAME
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_CLIP_ENABLE,
        REG_CLIP_LEFT,
        REG_CLIP_TOP,
        REG_CLIP_RIGHT,
        REG_CLIP_BOTTOM
    } cfg_idx_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [PIX_W-1:0] colour;
        logic [PIX_W-1:0] texel;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             written;
    } out_t;

    typedef struct packed {
        logic tint;
        logic load_src;
        logic load_mul;
    } blend_ctrl_t;

    // (v + 127) / 255 for v <= 255*255, by shift and add:
    // with t = 255k + r, t + 1 + (t >> 8) lands in [256k, 256k + 255].
    function automatic logic [CH_W-1:0] div255_round(input logic [2*CH_W-1:0] v);
        logic [2*CH_W:0] t;
        logic [2*CH_W:0] q;
        t = (2*CH_W+1)'(v) + (2*CH_W+1)'(ROUND_BIAS);
        q = t + (2*CH_W+1)'(1) + (t >> CH_W);
        return q[2*CH_W-1:CH_W];
    endfunction

endpackage

`default_nettype wire

// ----- design/ofb_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ofb_store
    import ofb_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int AW    = $clog2(DEF_MAX_WIDTH * DEF_MAX_HEIGHT)
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [PIX_W-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [PIX_W-1:0] rdata
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/ofb_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ofb_blend
    import ofb_pkg::*;
(
    input  wire logic             clk,
    input  wire blend_ctrl_t      ctrl,
    input  wire logic [PIX_W-1:0] colour,
    input  wire logic [PIX_W-1:0] texel,
    input  wire logic [PIX_W-1:0] dst,
    output      logic [PIX_W-1:0] src,
    output      logic [PIX_W-1:0] blended
);

    logic [PIX_W-1:0]  src_reg;
    logic [PIX_W-1:0]  tint;
    logic [2*CH_W-1:0] sum_reg [CHANNELS];
    logic [CH_W-1:0]   alpha;
    logic [CH_W-1:0]   inv;
    logic [CH_W:0]     da_sum;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            tint[c*CH_W +: CH_W] = div255_round((2*CH_W)'(texel[c*CH_W +: CH_W])
                                              * (2*CH_W)'(colour[c*CH_W +: CH_W]));
        end
    end

    assign alpha = src_reg[PIX_W-1 -: CH_W];
    assign inv   = ALPHA_OPAQUE - alpha;

    // Products are registered; the /255 rounding follows in the next cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_src)
        begin
            src_reg <= ctrl.tint ? tint : colour;
        end
        if (ctrl.load_mul)
        begin
            for (int c = 0; c < CHANNELS - 1; c++)
            begin
                sum_reg[c] <= (2*CH_W)'(src_reg[c*CH_W +: CH_W]) * (2*CH_W)'(alpha)
                            + (2*CH_W)'(dst[c*CH_W +: CH_W]) * (2*CH_W)'(inv);
            end
            sum_reg[CHANNELS-1] <= (2*CH_W)'(dst[PIX_W-1 -: CH_W]) * (2*CH_W)'(inv);
        end
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS - 1; c++)
        begin
            blended[c*CH_W +: CH_W] = div255_round(sum_reg[c]);
        end
        da_sum = (CH_W+1)'(alpha) + (CH_W+1)'(div255_round(sum_reg[CHANNELS-1]));
        blended[PIX_W-1 -: CH_W] = da_sum[CH_W] ? ALPHA_OPAQUE : da_sum[CH_W-1:0];
    end

    assign src = src_reg;

endmodule

`default_nettype wire

// ----- design/overlay_fragment_blend.sv -----
// Overlay blender over a BGRA8 frame store held in one synchronous RAM of
// MAX_WIDTH*MAX_HEIGHT words. One transaction is worked at a time: busy is
// high from acceptance until the result strobe. Blend, tint-blend and read
// transactions step through address, RAM read, multiply, round and write
// back; a new one is not taken before done, since the read-multiply-write
// walk runs through the single RAM. A frame start on a clean store returns
// done in the next cycle; on a dirty store it sweeps all MAX_WIDTH*MAX_HEIGHT
// words of the RAM one word a cycle and strobes done as the sweep ends. The
// same sweep runs after reset with busy high and no result. done is high for
// exactly one cycle with result valid; the receiver cannot stall it, so it
// must take every strobe.
// Configuration writes are taken at any time but belong only to idle periods.
`timescale 1ns / 1ps
`default_nettype none

`include "overlay_fragment_blend_defines.svh"

module overlay_fragment_blend
    import ofb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire in_t                   item,
    output      logic                  busy,
    output      logic                  done,
    output      out_t                  result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_WRITE
    } state_t;

    state_t state_reg;

    logic [FRAME_W-1:0] frame_width_reg;
    logic [FRAME_W-1:0] frame_height_reg;
    logic               clip_enable_reg;
    logic [CLIP_W-1:0]  clip_left_reg;
    logic [CLIP_W-1:0]  clip_top_reg;
    logic [CLIP_W-1:0]  clip_right_reg;
    logic [CLIP_W-1:0]  clip_bottom_reg;

    logic [AW-1:0]    clr_cnt_reg;
    logic             report_reg;
    logic             dirty_reg;
    logic             done_reg;
    out_t             result_reg;

    in_t              item_reg;
    logic [AW-1:0]    addr_reg;
    logic             inside_reg;
    logic             clipped_reg;

    logic [FRAME_W-1:0]     eff_w;
    logic [FRAME_W-1:0]     eff_h;
    logic                   in_frame;
    logic                   clip_hit;
    logic [ADDR_PROD_W-1:0] addr_full;
    logic                   accept;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [PIX_W-1:0] mem_wdata;
    logic             mem_re;
    logic [PIX_W-1:0] rdata;

    blend_ctrl_t      bctrl;
    logic [PIX_W-1:0] src;
    logic [PIX_W-1:0] blended;
    logic [PIX_W-1:0] new_pix;
    logic [PIX_W-1:0] out_pix;
    logic             is_frag;
    logic             frag_wr;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            clip_enable_reg  <= 1'b0;
            clip_left_reg    <= RST_CLIP_LEFT;
            clip_top_reg     <= RST_CLIP_TOP;
            clip_right_reg   <= RST_CLIP_RIGHT;
            clip_bottom_reg  <= RST_CLIP_BOTTOM;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_CLIP_ENABLE:  clip_enable_reg  <= cfg_data[0];
                REG_CLIP_LEFT:    clip_left_reg    <= cfg_data[CLIP_W-1:0];
                REG_CLIP_TOP:     clip_top_reg     <= cfg_data[CLIP_W-1:0];
                REG_CLIP_RIGHT:   clip_right_reg   <= cfg_data[CLIP_W-1:0];
                REG_CLIP_BOTTOM:  clip_bottom_reg  <= cfg_data[CLIP_W-1:0];
                default:          ;
            endcase
        end
    end

    // Position checks and store address, from the transaction at the ports
    always_comb
    begin
        eff_w = (int'(frame_width_reg) > MAX_WIDTH) ? FRAME_W'(MAX_WIDTH) : frame_width_reg;
        eff_h = (int'(frame_height_reg) > MAX_HEIGHT) ? FRAME_W'(MAX_HEIGHT)
                                                       : frame_height_reg;
        in_frame = (FRAME_W'(item.pos_x) < eff_w) && (FRAME_W'(item.pos_y) < eff_h);
        clip_hit = clip_enable_reg &&
                   ((item.pos_x < clip_left_reg) || (item.pos_x > clip_right_reg) ||
                    (item.pos_y < clip_top_reg)  || (item.pos_y > clip_bottom_reg));
        addr_full = ADDR_PROD_W'(item.pos_y) * ADDR_PROD_W'(eff_w)
                  + ADDR_PROD_W'(item.pos_x);
    end

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg    <= item;
            addr_reg    <= in_frame ? AW'(addr_full) : '0;
            inside_reg  <= in_frame;
            clipped_reg <= clip_hit;
        end
    end

    assign bctrl.tint     = (item_reg.op == OP_TINT);
    assign bctrl.load_src = (state_reg == S_READ);
    assign bctrl.load_mul = (state_reg == S_MUL);

    ofb_blend u_blend (
        .clk     (clk),
        .ctrl    (bctrl),
        .colour  (item_reg.colour),
        .texel   (item_reg.texel),
        .dst     (rdata),
        .src     (src),
        .blended (blended)
    );

    always_comb
    begin
        is_frag = (item_reg.op == OP_BLEND) || (item_reg.op == OP_TINT);
        frag_wr = is_frag && inside_reg && !clipped_reg && (src[PIX_W-1 -: CH_W] != '0);
        new_pix = (src[PIX_W-1 -: CH_W] == ALPHA_OPAQUE) ? src : blended;
        if (!inside_reg)
        begin
            out_pix = '0;
        end
        else if (frag_wr)
        begin
            out_pix = new_pix;
        end
        else
        begin
            out_pix = rdata;
        end
    end

    assign mem_we    = (state_reg == S_CLEAR) || ((state_reg == S_WRITE) && frag_wr);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : addr_reg;
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : new_pix;
    assign mem_re    = (state_reg == S_READ);

    ofb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            report_reg  <= 1'b0;
            dirty_reg   <= 1'b0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_cnt_reg == LAST_ADDR)
                    begin
                        state_reg  <= S_IDLE;
                        report_reg <= 1'b0;
                        if (report_reg)
                        begin
                            done_reg           <= 1'b1;
                            result_reg.pixel   <= '0;
                            result_reg.written <= 1'b1;
                        end
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (item.op == OP_FRAME)
                        begin
                            if (dirty_reg)
                            begin
                                state_reg   <= S_CLEAR;
                                clr_cnt_reg <= '0;
                                report_reg  <= 1'b1;
                                dirty_reg   <= 1'b0;
                            end
                            else
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '0;
                            end
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    state_reg          <= S_IDLE;
                    done_reg           <= 1'b1;
                    result_reg.pixel   <= out_pix;
                    result_reg.written <= frag_wr;
                    if (frag_wr)
                    begin
                        dirty_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `OFB_ASSERT_SAME(a_done_when_idle, done, !busy, "result strobed while busy")

    `OFB_ASSERT_SAME(a_write_marks_dirty, done && result.written && (item_reg.op != OP_FRAME),
                     dirty_reg, "fragment write left the store clean")

    `OFB_ASSERT_SAME(a_outside_is_zero,
                     done && (item_reg.op != OP_FRAME) && !inside_reg,
                     (result.pixel == '0) && !result.written,
                     "out-of-frame transaction returned data or wrote")

    `OFB_ASSERT_NEXT(a_dirty_start_sweeps,
                     accept && (item.op == OP_FRAME) && dirty_reg,
                     busy && (state_reg == S_CLEAR) && !dirty_reg,
                     "frame start on a dirty store did not sweep")

endmodule

`default_nettype wire
